// File: rtl/i2cwps_pkg.sv
`timescale 1ns / 1ps

package i2cwps_pkg;

    // Largest buffer the parser accepts; longer lengths clamp to it.
    localparam int BUFFER_BYTES = 64;

    // Buffer byte counter, wide enough to hold BUFFER_BYTES itself.
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    // Width for clamping the 7-bit length field against BUFFER_BYTES.
    localparam int CLAMP_W = (CNT_W > 7) ? CNT_W : 7;
    // Width for checking a record length byte against the bytes left.
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_ADDR = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_buffer;
        logic [6:0] buffer_length;
    } in_item_t;

    typedef struct packed {
        logic       command_kind;
        logic [7:0] command_value;
        logic       final_byte;
    } out_item_t;

    // Result handed from the parser to the output buffer.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

// File: rtl/i2cwps_parser.sv
`timescale 1ns / 1ps

module i2cwps_parser
    import i2cwps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output result_t  result
);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [7:0]        rec_left_reg, rec_left_next;
    logic [7:0]        address_reg, address_next;

    logic [CLAMP_W-1:0] blen_ext;
    logic [CNT_W-1:0]   blen_clamped;
    phase_t             phase_eff;
    logic [CNT_W-1:0]   left;
    logic [7:0]         rec_eff;
    logic [CMP_W-1:0]   len_cmp;
    logic [CMP_W-1:0]   room_cmp;
    logic               rec_last;

    always_comb
    begin
        blen_ext = CLAMP_W'(item.buffer_length);
        if (blen_ext > CLAMP_W'(BUFFER_BYTES))
        begin
            blen_clamped = CNT_W'(BUFFER_BYTES);
        end
        else
        begin
            blen_clamped = CNT_W'(blen_ext);
        end

        phase_eff = item.first_of_buffer ? PH_ADDR : phase_reg;
        left      = item.first_of_buffer ? blen_clamped : remain_reg;
        rec_eff   = item.first_of_buffer ? 8'd0 : rec_left_reg;
        len_cmp   = CMP_W'(item.data_byte);
        room_cmp  = CMP_W'(left) - CMP_W'(1);
        rec_last  = (rec_eff <= 8'd1);

        phase_next    = phase_eff;
        remain_next   = left;
        rec_left_next = rec_eff;
        address_next  = address_reg;
        result        = '0;

        if (left == '0)
        begin
            phase_next = PH_SKIP;
        end
        else
        begin
            remain_next = left - CNT_W'(1);
            case (phase_eff)
                PH_ADDR:
                begin
                    if (left > CNT_W'(2))
                    begin
                        address_next = item.data_byte;
                        phase_next   = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_LEN:
                begin
                    if ((len_cmp != '0) && (len_cmp <= room_cmp))
                    begin
                        rec_left_next             = item.data_byte;
                        phase_next                = PH_DATA;
                        result.valid              = 1'b1;
                        result.item.command_kind  = CMD_START;
                        result.item.command_value = address_reg;
                        result.item.final_byte    = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_DATA:
                begin
                    result.valid              = 1'b1;
                    result.item.command_kind  = CMD_WRITE;
                    result.item.command_value = item.data_byte;
                    result.item.final_byte    = rec_last;
                    if (rec_last)
                    begin
                        rec_left_next = 8'd0;
                        phase_next    = PH_ADDR;
                    end
                    else
                    begin
                        rec_left_next = rec_eff - 8'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end

        if (!accept)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SKIP;
            remain_reg   <= '0;
            rec_left_reg <= 8'd0;
            address_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            remain_reg   <= remain_next;
            rec_left_reg <= rec_left_next;
            address_reg  <= address_next;
        end
    end

endmodule

// File: rtl/i2cwps_skid.sv
`timescale 1ns / 1ps

module i2cwps_skid
    import i2cwps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   push,
    output logic      full,
    output logic      valid,
    input  logic      stall,
    output out_item_t item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_item_reg, skid_item_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;

        if (!out_valid_reg || !stall)
        begin
            // Output slot frees up: drain the skid first, else take the new result.
            out_valid_next  = skid_valid_reg || push.valid;
            out_item_next   = skid_valid_reg ? skid_item_reg : push.item;
            skid_valid_next = 1'b0;
        end
        else if (push.valid)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign item  = out_item_reg;

endmodule

// File: rtl/i2c_write_packet_splitter.sv
`timescale 1ns / 1ps

// Splits a received buffer, fed one byte per item, into I2C commands. The
// first byte's item carries first_of_buffer and the buffer's total length
// (clamped to BUFFER_BYTES). The buffer holds records of an address byte, a
// length byte and that many data bytes; a valid length byte yields a start
// command with the address, and each data byte yields a write command, the
// record's last one flagged with final_byte. A bad length, or too few bytes
// left for a header and one data byte, drops the rest of the buffer without
// output. The parse state updates in the cycle an item is accepted and any
// command lands in the output or, behind a stalled output, the skid register
// on the same edge, so a new item can enter every clock while src_stall is
// low. A two-entry output buffer (output plus skid register) keeps src_stall
// registered; it rises only while a command is parked in the skid register.

module i2c_write_packet_splitter
    import i2cwps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_item
);

    logic    accept;
    result_t result;
    logic    skid_full;

    // Take an item whenever the skid register is free.
    assign src_stall = skid_full;
    assign accept    = src_valid && !skid_full;

    i2cwps_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_item),
        .result (result)
    );

    i2cwps_skid u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result),
        .full  (skid_full),
        .valid (dst_valid),
        .stall (dst_stall),
        .item  (dst_item)
    );

endmodule
